FILE: rtl/dual_ultrasonic_echo_ranger_core_defines.svh
// Assertion helpers for the echo ranger core.
`ifndef DUAL_ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define DUAL_ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define DURNG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("durng assertion failed");

// checked at every edge, reset included
`define DURNG_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("durng assertion failed");

`else

`define DURNG_ASSERT(lbl, clk, rstn, prop)
`define DURNG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/durng_pkg.sv
package durng_pkg;

	localparam int OUT_W       = 8;
	localparam int TICK_W      = 8;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 1'b1;

	localparam logic [CFG_W-1:0] TRIGGER_TICKS_RST  = 8'd10;
	localparam logic [CFG_W-1:0] TICKS_PER_UNIT_RST = 8'd116;

	// sensor selector codes
	localparam logic [1:0] SEL_RIGHT = 2'd0;
	localparam logic [1:0] SEL_LEFT  = 2'd1;

	// last field in the lowest bits
	typedef struct packed {
		logic [1:0] sensor_select;
		logic       echo_left;
		logic       echo_right;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic             done_res;
		logic             busy_res;
		logic [OUT_W-1:0] selected_range;
		logic [OUT_W-1:0] range_left;
		logic [OUT_W-1:0] range_right;
		logic             trig_left;
		logic             trig_right;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] ticks_per_unit;
		logic [CFG_W-1:0] trigger_ticks;
	} cfg_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

FILE: rtl/durng_ctrl.sv
module durng_ctrl #(
	parameter int RANGE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  durng_pkg::item_t   item,
	input  durng_pkg::cfg_t    cfg,
	output durng_pkg::result_t result
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TRIG_R  = 3'd1,
		PH_WAIT_R  = 3'd2,
		PH_COUNT_R = 3'd3,
		PH_TRIG_L  = 3'd4,
		PH_WAIT_L  = 3'd5,
		PH_COUNT_L = 3'd6
	} phase_t;

	localparam logic [RANGE_BITS-1:0] RANGE_MAX = {RANGE_BITS{1'b1}};
	localparam logic [RANGE_BITS-1:0] RANGE_ONE = {{(RANGE_BITS-1){1'b0}}, 1'b1};

	phase_t                          phase_q, phase_d;
	logic [durng_pkg::TICK_W-1:0]    pulse_q, pulse_d;
	logic [durng_pkg::TICK_W-1:0]    sub_q, sub_d;
	logic [RANGE_BITS-1:0]           acc_q, acc_d;
	logic [RANGE_BITS-1:0]           held_r_q, held_r_d;
	logic [RANGE_BITS-1:0]           held_l_q, held_l_d;
	logic                            done;

	logic [durng_pkg::TICK_W-1:0]    pulse_len, unit_div;
	logic                            first_tick;
	logic [durng_pkg::TICK_W-1:0]    base_sub, sub_inc, tick_sub;
	logic [RANGE_BITS-1:0]           base_acc, tick_acc;
	logic                            unit_wrap;
	logic [RANGE_BITS-1:0]           sel_val;

	// zero register values act as 1
	assign pulse_len = (cfg.trigger_ticks == '0) ? 8'd1 : cfg.trigger_ticks;
	assign unit_div  = (cfg.ticks_per_unit == '0) ? 8'd1 : cfg.ticks_per_unit;

	// one echo tick: rising edge restarts the divider from zero
	assign first_tick = (phase_q == PH_WAIT_R) || (phase_q == PH_WAIT_L);
	assign base_sub   = first_tick ? '0 : sub_q;
	assign base_acc   = first_tick ? '0 : acc_q;
	assign sub_inc    = base_sub + 8'd1;
	assign unit_wrap  = (sub_inc >= unit_div);
	assign tick_sub   = unit_wrap ? '0 : sub_inc;
	assign tick_acc   = (unit_wrap && (base_acc != RANGE_MAX)) ? base_acc + RANGE_ONE : base_acc;

	always_comb begin
		phase_d  = phase_q;
		pulse_d  = pulse_q;
		sub_d    = sub_q;
		acc_d    = acc_q;
		held_r_d = held_r_q;
		held_l_d = held_l_q;
		done     = 1'b0;
		unique case (phase_q)
			PH_TRIG_R: begin
				if (pulse_q >= pulse_len) begin
					phase_d = PH_WAIT_R;
				end else begin
					pulse_d = pulse_q + 8'd1;
				end
			end
			PH_WAIT_R: begin
				if (item.echo_right) begin
					sub_d   = tick_sub;
					acc_d   = tick_acc;
					phase_d = PH_COUNT_R;
				end
			end
			PH_COUNT_R: begin
				if (item.echo_right) begin
					sub_d = tick_sub;
					acc_d = tick_acc;
				end else begin
					held_r_d = acc_q;
					pulse_d  = 8'd1;
					phase_d  = PH_TRIG_L;
				end
			end
			PH_TRIG_L: begin
				if (pulse_q >= pulse_len) begin
					phase_d = PH_WAIT_L;
				end else begin
					pulse_d = pulse_q + 8'd1;
				end
			end
			PH_WAIT_L: begin
				if (item.echo_left) begin
					sub_d   = tick_sub;
					acc_d   = tick_acc;
					phase_d = PH_COUNT_L;
				end
			end
			PH_COUNT_L: begin
				if (item.echo_left) begin
					sub_d = tick_sub;
					acc_d = tick_acc;
				end else begin
					held_l_d = acc_q;
					phase_d  = PH_IDLE;
					done     = 1'b1;
				end
			end
			default: begin
				// idle and the unused code
				phase_d = PH_IDLE;
				if (item.start_req) begin
					pulse_d = 8'd1;
					phase_d = PH_TRIG_R;
				end
			end
		endcase
	end

	always_comb begin
		case (item.sensor_select)
			durng_pkg::SEL_RIGHT: sel_val = held_r_d;
			durng_pkg::SEL_LEFT:  sel_val = held_l_d;
			default:              sel_val = '0;
		endcase
	end

	// result reflects the state after this tick
	always_comb begin
		result.trig_right     = (phase_d == PH_TRIG_R);
		result.trig_left      = (phase_d == PH_TRIG_L);
		result.range_right    = held_r_d[durng_pkg::OUT_W-1:0];
		result.range_left     = held_l_d[durng_pkg::OUT_W-1:0];
		result.selected_range = sel_val[durng_pkg::OUT_W-1:0];
		result.busy_res       = (phase_d != PH_IDLE);
		result.done_res       = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pulse_q  <= '0;
			sub_q    <= '0;
			acc_q    <= '0;
			held_r_q <= '0;
			held_l_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			pulse_q  <= pulse_d;
			sub_q    <= sub_d;
			acc_q    <= acc_d;
			held_r_q <= held_r_d;
			held_l_q <= held_l_d;
		end
	end

endmodule

FILE: rtl/dual_ultrasonic_echo_ranger_core.sv
// Channel  | Dir | tdata fields (low bit up)                       | tuser
// s_axis   | in  | start_req, echo_right, echo_left, sensor_select | -
// m_axis   | out | trig_right, trig_left, range_right, range_left, | -
//          |     | selected_range, busy_res, done_res              |
// cfg      | in  | cfg_we / cfg_index / cfg_data, no read-back     | -
//
// One tick word per cycle while s_tready is high; its result word is registered.
// Measurement state and a two-entry output register (main + skid) set the rate.
// s_tready drops only while the skid entry holds a word; no word is lost or dropped.
// arst_n clears state, counters, held ranges and output valids; config regs
// return to trigger_ticks 10, ticks_per_unit 116.
`include "dual_ultrasonic_echo_ranger_core_defines.svh"

module dual_ultrasonic_echo_ranger_core #(
	parameter int RANGE_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// start_req[0], echo_right[1], echo_left[2], sensor_select[4:3], zero fill
	input  logic [durng_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// trig_right[0], trig_left[1], range_right[9:2], range_left[17:10],
	// selected_range[25:18], busy_res[26], done_res[27], zero fill
	output logic [durng_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	input  logic                                   cfg_we,
	input  logic [durng_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [durng_pkg::CFG_W-1:0]            cfg_data
);

	durng_pkg::cfg_t    cfg_q;
	durng_pkg::item_t   item;
	durng_pkg::result_t result;
	durng_pkg::result_t main_q, skid_q;
	logic               main_vld_q, skid_vld_q;
	logic               in_acc, out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks  <= durng_pkg::TRIGGER_TICKS_RST;
			cfg_q.ticks_per_unit <= durng_pkg::TICKS_PER_UNIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				durng_pkg::REG_TRIGGER_TICKS:  cfg_q.trigger_ticks  <= cfg_data;
				durng_pkg::REG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item     = durng_pkg::item_t'(s_tdata[durng_pkg::ITEM_W-1:0]);
	assign s_tready = !skid_vld_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = main_vld_q && m_tready;

	durng_ctrl #(
		.RANGE_BITS(RANGE_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_acc),
		.item   (item),
		.cfg    (cfg_q),
		.result (result)
	);

	// skid word goes out first once the main word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_acc) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_acc) begin
			if (!main_vld_q || out_acc) begin
				main_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_acc) begin
			main_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_acc) begin
				main_q <= skid_q;
			end
		end else if (in_acc) begin
			if (!main_vld_q || out_acc) begin
				main_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	assign m_tvalid = main_vld_q;
	assign m_tdata  = {{(durng_pkg::OUT_TDATA_W - durng_pkg::RESULT_W){1'b0}}, main_q};

	`DURNG_ASSERT(a_skid_behind_main, clk, arst_n, skid_vld_q |-> main_vld_q)
	`DURNG_ASSERT(a_one_trigger, clk, arst_n, main_vld_q |-> !(main_q.trig_right && main_q.trig_left))
	`DURNG_ASSERT(a_done_ends_cycle, clk, arst_n, (main_vld_q && main_q.done_res) |-> !main_q.busy_res)
	`DURNG_ASSERT_ALWAYS(a_reset_empties, clk, !arst_n |=> (!main_vld_q && !skid_vld_q))

endmodule

FILE: sim/tb_dual_ultrasonic_echo_ranger_core.sv
module tb_dual_ultrasonic_echo_ranger_core;

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 6;
	localparam int PHASE_TICKS = 35;

	// selector values with no sensor behind them
	localparam logic [1:0] SEL_NONE  = 2'd2;
	localparam logic [1:0] SEL_SPARE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIG_R,
		ST_WAIT_R,
		ST_COUNT_R,
		ST_TRIG_L,
		ST_WAIT_L,
		ST_COUNT_L
	} ranger_phase_t;

	typedef struct packed {
		durng_pkg::item_t   word;
		logic               typed;
		durng_pkg::result_t want;
	} dir_row_t;

	localparam durng_pkg::result_t NO_RES = '0;

	logic                              clk;
	logic                              arst_n;
	logic [durng_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [durng_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic                              cfg_we;
	logic [durng_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [durng_pkg::CFG_W-1:0]       cfg_data;

	dual_ultrasonic_echo_ranger_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predicted block state and registers
	ranger_phase_t ph;
	logic [7:0]    pulse_cnt;
	logic [7:0]    sub_cnt;
	logic [7:0]    dist_acc;
	logic [7:0]    hold_r;
	logic [7:0]    hold_l;
	logic [7:0]    trig_len;
	logic [7:0]    tick_div;

	durng_pkg::result_t range_q[$];
	dir_row_t           dir_tab[$];
	int                 fails     = 0;
	int                 src_idle  = 38;
	int                 dst_idle  = 70;
	int                 n_ticks   = 0;
	int                 sat_left  = 1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void count_unit();
		logic [7:0] div;
		div = (tick_div == 8'd0) ? 8'd1 : tick_div;
		sub_cnt = sub_cnt + 8'd1;
		if (sub_cnt >= div) begin
			sub_cnt = 8'd0;
			if (dist_acc != 8'hFF)
				dist_acc = dist_acc + 8'd1;
		end
	endfunction

	function automatic bit trigger_over();
		logic [7:0] len;
		len = (trig_len == 8'd0) ? 8'd1 : trig_len;
		if (pulse_cnt >= len)
			return 1'b1;
		pulse_cnt = pulse_cnt + 8'd1;
		return 1'b0;
	endfunction

	function automatic durng_pkg::result_t ranger_step(input durng_pkg::item_t it);
		durng_pkg::result_t r;
		logic               done;
		done = 1'b0;
		case (ph)
			ST_TRIG_R: begin
				if (trigger_over())
					ph = ST_WAIT_R;
			end
			ST_WAIT_R: begin
				if (it.echo_right) begin
					sub_cnt  = 8'd0;
					dist_acc = 8'd0;
					count_unit();
					ph = ST_COUNT_R;
				end
			end
			ST_COUNT_R: begin
				if (it.echo_right) begin
					count_unit();
				end else begin
					hold_r    = dist_acc;
					pulse_cnt = 8'd1;
					ph        = ST_TRIG_L;
				end
			end
			ST_TRIG_L: begin
				if (trigger_over())
					ph = ST_WAIT_L;
			end
			ST_WAIT_L: begin
				if (it.echo_left) begin
					sub_cnt  = 8'd0;
					dist_acc = 8'd0;
					count_unit();
					ph = ST_COUNT_L;
				end
			end
			ST_COUNT_L: begin
				if (it.echo_left) begin
					count_unit();
				end else begin
					hold_l = dist_acc;
					ph     = ST_IDLE;
					done   = 1'b1;
				end
			end
			default: begin
				ph = ST_IDLE;
				if (it.start_req) begin
					pulse_cnt = 8'd1;
					ph        = ST_TRIG_R;
				end
			end
		endcase
		r.trig_right  = (ph == ST_TRIG_R);
		r.trig_left   = (ph == ST_TRIG_L);
		r.range_right = hold_r;
		r.range_left  = hold_l;
		if (it.sensor_select == durng_pkg::SEL_RIGHT)
			r.selected_range = hold_r;
		else if (it.sensor_select == durng_pkg::SEL_LEFT)
			r.selected_range = hold_l;
		else
			r.selected_range = '0;
		r.busy_res = (ph != ST_IDLE);
		r.done_res = done;
		return r;
	endfunction

	function automatic durng_pkg::item_t mk_tick(input logic st, input logic er,
		input logic el, input logic [1:0] sel);
		durng_pkg::item_t it;
		it.start_req     = st;
		it.echo_right    = er;
		it.echo_left     = el;
		it.sensor_select = sel;
		return it;
	endfunction

	function automatic durng_pkg::result_t mk_res(input logic tr, input logic tl,
		input logic [7:0] rr, input logic [7:0] rl, input logic [7:0] sr, input logic busy,
		input logic done);
		durng_pkg::result_t r;
		r.trig_right     = tr;
		r.trig_left      = tl;
		r.range_right    = rr;
		r.range_left     = rl;
		r.selected_range = sr;
		r.busy_res       = busy;
		r.done_res       = done;
		return r;
	endfunction

	function automatic durng_pkg::item_t rand_tick();
		return mk_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 2'($urandom_range(3)));
	endfunction

	// echo length in ticks; one long echo at one tick per unit reaches saturation
	function automatic int echo_len(input int div);
		if (div == 1 && sat_left > 0) begin
			sat_left--;
			return int'($urandom_range(256, 262));
		end
		return int'($urandom_range(1, (div > 12) ? 40 : 2 * div + 3));
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_tick(input durng_pkg::item_t it, input bit typed,
		input durng_pkg::result_t want);
		durng_pkg::result_t pred;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(durng_pkg::IN_TDATA_W - durng_pkg::ITEM_W){1'b0}}, it};
		do @(posedge clk); while (!s_tready);
		pred = ranger_step(it);
		range_q.push_back(typed ? want : pred);
		n_ticks++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (range_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] trig, input logic [7:0] div);
		cfg_we    <= 1'b1;
		cfg_index <= durng_pkg::REG_TRIGGER_TICKS;
		cfg_data  <= trig;
		@(negedge clk);
		cfg_index <= durng_pkg::REG_TICKS_PER_UNIT;
		cfg_data  <= div;
		@(negedge clk);
		cfg_we   <= 1'b0;
		trig_len  = trig;
		tick_div  = div;
	endtask

	// one well-formed right-then-left measurement, or the rest of one under way
	task automatic run_cycle();
		durng_pkg::item_t it;
		int               div;
		int               wr;
		int               wl;
		int               nr;
		int               nl;
		int               hr;
		int               hl;
		div = (tick_div == 8'd0) ? 1 : int'(tick_div);
		wr  = int'($urandom_range(0, 4));
		wl  = int'($urandom_range(0, 4));
		nr  = echo_len(div);
		nl  = echo_len(div);
		hr  = 0;
		hl  = 0;
		do begin
			it = rand_tick();
			case (ph)
				ST_IDLE: it.start_req = 1'b1;
				ST_WAIT_R: begin
					it.echo_right = (wr == 0);
					if (wr > 0)
						wr--;
					else
						hr = 1;
				end
				ST_COUNT_R: begin
					it.echo_right = (hr < nr);
					hr++;
				end
				ST_WAIT_L: begin
					it.echo_left = (wl == 0);
					if (wl > 0)
						wl--;
					else
						hl = 1;
				end
				ST_COUNT_L: begin
					it.echo_left = (hl < nl);
					hl++;
				end
				default: ;
			endcase
			send_tick(it, 1'b0, NO_RES);
		end while (ph != ST_IDLE);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= dst_idle);

	always @(posedge clk) begin : result_mon
		durng_pkg::result_t got;
		durng_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = durng_pkg::result_t'(m_tdata[durng_pkg::RESULT_W-1:0]);
			if (range_q.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				fails++;
			end else begin
				want = range_q.pop_front();
				check_field("trig_right", 32'(want.trig_right), 32'(got.trig_right));
				check_field("trig_left", 32'(want.trig_left), 32'(got.trig_left));
				check_field("range_right", 32'(want.range_right), 32'(got.range_right));
				check_field("range_left", 32'(want.range_left), 32'(got.range_left));
				check_field("selected_range", 32'(want.selected_range),
					32'(got.selected_range));
				check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
				check_field("done_res", 32'(want.done_res), 32'(got.done_res));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int target;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		ph        = ST_IDLE;
		pulse_cnt = '0;
		sub_cnt   = '0;
		dist_acc  = '0;
		hold_r    = '0;
		hold_l    = '0;
		trig_len  = durng_pkg::TRIGGER_TICKS_RST;
		tick_div  = durng_pkg::TICKS_PER_UNIT_RST;

		// zero registers act as one: one-tick trigger, one tick per unit
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b0, durng_pkg::SEL_RIGHT), 1'b1,
			mk_res(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0)});
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b1, SEL_SPARE), 1'b1,
			mk_res(1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0)});
		dir_tab.push_back({mk_tick(1'b1, 1'b0, 1'b0, SEL_NONE), 1'b1,
			mk_res(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0)});
		// start while busy
		dir_tab.push_back({mk_tick(1'b1, 1'b0, 1'b1, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b1, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		// first echo tick counts
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b1, 1'b1, 1'b1, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		// right range held
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b1, 1'b1, 1'b1, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b0, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b1, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b1, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		// done
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b0, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b0, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b0, SEL_NONE), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b1, SEL_SPARE), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b1, 1'b1, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		// echo during trigger
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b1, 1'b0, durng_pkg::SEL_RIGHT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b1, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b1, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b1, durng_pkg::SEL_LEFT), 1'b0, NO_RES});
		dir_tab.push_back({mk_tick(1'b0, 1'b0, 1'b0, durng_pkg::SEL_LEFT), 1'b0, NO_RES});

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_config(8'd0, 8'd0);
		foreach (dir_tab[i])
			send_tick(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(8'd1, 8'd1);
				1: set_config(8'd16, 8'd255);
				2: set_config(8'd0, 8'd0);
				3: set_config(8'($urandom_range(1, 20)), 8'($urandom_range(1, 8)));
				4: set_config(8'd2, 8'd3);
				default: set_config(8'($urandom_range(0, 30)), 8'($urandom_range(1, 40)));
			endcase
			case (p / 2)
				0: begin
					src_idle = 38;
					dst_idle = 70;
				end
				1: begin
					src_idle = 70;
					dst_idle = 38;
				end
				default: begin
					src_idle = 0;
					dst_idle = 0;
				end
			endcase
			target = n_ticks + PHASE_TICKS;
			while (n_ticks < target) begin
				if ($urandom_range(3) != 0)
					run_cycle();
				else
					repeat ($urandom_range(1, 5)) send_tick(rand_tick(), 1'b0, NO_RES);
			end
			if (ph != ST_IDLE)
				run_cycle();
			settle();
		end

		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
